/* hw/rtl/sorted_key_table_top_assert.svh */
// ---------------------------------------------------------------------------
// sorted_key_table_top_assert.svh
// Assertion macros used by the checker file of the sorted key table.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted key table assertion failed");

// next-cycle implication
`define SKT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted key table assertion failed");

`endif

/* hw/rtl/skt_pkg.sv */
// ---------------------------------------------------------------------------
// skt_pkg
// Types, codes and helpers shared by the sorted key table.
// ---------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int KEY_BYTES = 16;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int OCC_W    = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUP       = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_FCHK,
    S_FEQ,
    S_ACT,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key_hi;
    logic [KEY_W-1:0]    key_lo;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // zero the bytes past KEY_BYTES and everything after the first zero byte
  function automatic logic [2*KEY_W-1:0] norm_key(input logic [2*KEY_W-1:0] k);
    logic [2*KEY_W-1:0] r;
    logic               ended;
    logic [7:0]         b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < 16; i++) begin
      b = k[2*KEY_W-1-8*i -: 8];
      if ((i >= KEY_BYTES) || ended) begin
        b = '0;
      end
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      r[2*KEY_W-1-8*i -: 8] = b;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/skt_chan_if.sv */
// ---------------------------------------------------------------------------
// skt_chan_if
// Request and response channels of the sorted key table, valid/ready.
// ---------------------------------------------------------------------------
interface skt_req_if;
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::ACTION_W-1:0]  action;
  logic [skt_pkg::KEY_W-1:0]     key_high;
  logic [skt_pkg::KEY_W-1:0]     key_low;
  logic [skt_pkg::HANDLE_W-1:0]  handle_in;

  modport source (output valid, action, key_high, key_low, handle_in, input ready);
  modport sink   (input valid, action, key_high, key_low, handle_in, output ready);
endinterface

interface skt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::STATUS_W-1:0]  status;
  logic [skt_pkg::POS_W-1:0]     position;
  logic [skt_pkg::HANDLE_W-1:0]  handle_out;
  logic [skt_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, status, position, handle_out, occupancy, input ready);
  modport sink   (input valid, status, position, handle_out, occupancy, output ready);
endinterface

/* hw/rtl/skt_entry_ram.sv */
// ---------------------------------------------------------------------------
// skt_entry_ram
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module skt_entry_ram #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic [AW-1:0]   rd_addr,
  output skt_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  skt_pkg::entry_t wr_data
);
  import skt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/sorted_key_table_top.sv */
// ---------------------------------------------------------------------------
// sorted_key_table_top
// Sorted table of 128-bit keys with 32-bit handles: insert, delete, lookup.
// ---------------------------------------------------------------------------
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// Every item runs a binary search through the entry RAM, one read and one
// 128-bit compare per step. Insert and delete then move the entries past
// the found place one slot, one entry per cycle through the RAM's read and
// write ports. A finished result sits in the output register while the
// next item is taken. No clearing pass.
module sorted_key_table_top #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input logic           clk,
  input logic           rst_n,
  skt_req_if.sink       in_ch,
  skt_rsp_if.source     out_ch
);
  import skt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                state_r, state_nxt;
  logic [2*KEY_W-1:0]    key_r, key_nxt;
  logic [ACTION_W-1:0]   action_r, action_nxt;
  logic [HANDLE_W-1:0]   hin_r, hin_nxt;
  logic [CW-1:0]         a_r, a_nxt;
  logic [CW-1:0]         b_r, b_nxt;
  logic [CW-1:0]         m_r, m_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  found_r, found_nxt;
  logic [HANDLE_W-1:0]   hf_r, hf_nxt;
  logic [AW-1:0]         sh_rd_r, sh_rd_nxt;
  logic                  sh_act_r, sh_act_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         pend_wa_r, pend_wa_nxt;
  status_t               res_st_r, res_st_nxt;
  logic [HANDLE_W-1:0]   res_h_r, res_h_nxt;
  logic                  ov_r, ov_nxt;
  status_t               o_st_r, o_st_nxt;
  logic [POS_W-1:0]      o_pos_r, o_pos_nxt;
  logic [HANDLE_W-1:0]   o_h_r, o_h_nxt;
  logic [OCC_W-1:0]      o_occ_r, o_occ_nxt;

  logic [AW-1:0]         rd_addr;
  entry_t                rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  entry_t                wr_data;

  logic                  in_acc;
  logic                  out_free;
  logic [CW-1:0]         mid;
  logic                  key_lt;
  logic                  key_eq;
  logic                  sh_done;
  logic                  sh_last;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         a_p1;

  skt_entry_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_acc   = in_ch.valid && (state_r == S_IDLE);
  assign out_free = !ov_r || out_ch.ready;
  assign mid      = a_r + ((b_r - a_r) >> 1);
  assign key_lt   = {rd_data.key_hi, rd_data.key_lo} < key_r;
  assign key_eq   = {rd_data.key_hi, rd_data.key_lo} == key_r;
  assign sh_done  = !sh_act_r && !pend_r;
  assign cnt_m1   = cnt_r - CW'(1);
  assign a_p1     = a_r + CW'(1);
  assign sh_last  = (action_r == ACT_INSERT) ? (CW'(sh_rd_r) == a_r)
                                             : (CW'(sh_rd_r) == cnt_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SRCH;
      end
      S_SRCH: begin
        state_nxt = (a_r < b_r) ? S_SCMP : S_FCHK;
      end
      S_SCMP: state_nxt = S_SRCH;
      S_FCHK: begin
        state_nxt = (a_r < cnt_r) ? S_FEQ : S_ACT;
      end
      S_FEQ: state_nxt = S_ACT;
      S_ACT: begin
        state_nxt = S_DONE;
        if ((action_r == ACT_INSERT) && (cnt_r != CW'(DEPTH)) && !found_r) begin
          state_nxt = S_SHIFT;
        end
        if ((action_r == ACT_DELETE) && found_r) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_done) state_nxt = (action_r == ACT_INSERT) ? S_WRITE : S_DONE;
      end
      S_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    key_nxt     = key_r;
    action_nxt  = action_r;
    hin_nxt     = hin_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    m_nxt       = m_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    hf_nxt      = hf_r;
    sh_rd_nxt   = sh_rd_r;
    sh_act_nxt  = sh_act_r;
    pend_nxt    = pend_r;
    pend_wa_nxt = pend_wa_r;
    res_st_nxt  = res_st_r;
    res_h_nxt   = res_h_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_st_nxt    = o_st_r;
    o_pos_nxt   = o_pos_r;
    o_h_nxt     = o_h_r;
    o_occ_nxt   = o_occ_r;
    rd_addr     = m_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pend_wa_r;
    wr_data     = rd_data;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt    = norm_key({in_ch.key_high, in_ch.key_low});
          action_nxt = in_ch.action;
          hin_nxt    = in_ch.handle_in;
          a_nxt      = '0;
          b_nxt      = cnt_r;
          found_nxt  = 1'b0;
        end
      end
      S_SRCH: begin
        rd_addr = mid[AW-1:0];
        m_nxt   = mid;
      end
      S_SCMP: begin
        if (key_lt) a_nxt = m_r + CW'(1);
        else        b_nxt = m_r;
      end
      S_FCHK: begin
        rd_addr   = a_r[AW-1:0];
        found_nxt = 1'b0;
      end
      S_FEQ: begin
        found_nxt = key_eq;
        hf_nxt    = rd_data.handle;
      end
      S_ACT: begin
        res_st_nxt = ST_NOT_FOUND;
        res_h_nxt  = '0;
        pend_nxt   = 1'b0;
        case (action_r)
          ACT_INSERT: begin
            if (cnt_r == CW'(DEPTH)) begin
              res_st_nxt = ST_FULL;
            end else if (found_r) begin
              res_st_nxt = ST_DUP;
            end else begin
              res_st_nxt = ST_OK;
              sh_act_nxt = (cnt_r != a_r);
              sh_rd_nxt  = cnt_m1[AW-1:0];
            end
          end
          ACT_DELETE: begin
            if (found_r) begin
              res_st_nxt = ST_OK;
              sh_act_nxt = (a_p1 < cnt_r);
              sh_rd_nxt  = a_p1[AW-1:0];
            end
          end
          ACT_LOOKUP: begin
            if (found_r) begin
              res_st_nxt = ST_OK;
              res_h_nxt  = hf_r;
            end
          end
          default: res_st_nxt = ST_NOT_FOUND;
        endcase
      end
      S_SHIFT: begin
        rd_addr = sh_rd_r;
        wr_en   = pend_r;
        pend_nxt = sh_act_r;
        if (sh_act_r) begin
          if (action_r == ACT_INSERT) begin
            pend_wa_nxt = sh_rd_r + AW'(1);
            sh_rd_nxt   = sh_rd_r - AW'(1);
          end else begin
            pend_wa_nxt = sh_rd_r - AW'(1);
            sh_rd_nxt   = sh_rd_r + AW'(1);
          end
          if (sh_last) sh_act_nxt = 1'b0;
        end
        if (sh_done && (action_r == ACT_DELETE)) cnt_nxt = cnt_m1;
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = a_r[AW-1:0];
        wr_data = '{key_hi: key_r[2*KEY_W-1:KEY_W], key_lo: key_r[KEY_W-1:0],
                    handle: hin_r};
        cnt_nxt = cnt_r + CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_st_nxt  = res_st_r;
          o_pos_nxt = ((res_st_r == ST_OK) || (res_st_r == ST_DUP)) ? POS_W'(a_r) : '0;
          o_h_nxt   = res_h_r;
          o_occ_nxt = OCC_W'(cnt_r);
        end
      end
      default: begin
        ov_nxt = ov_r && !out_ch.ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
      sh_act_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
      sh_act_r <= sh_act_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    action_r  <= action_nxt;
    hin_r     <= hin_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    m_r       <= m_nxt;
    found_r   <= found_nxt;
    hf_r      <= hf_nxt;
    sh_rd_r   <= sh_rd_nxt;
    pend_wa_r <= pend_wa_nxt;
    res_st_r  <= res_st_nxt;
    res_h_r   <= res_h_nxt;
    o_st_r    <= o_st_nxt;
    o_pos_r   <= o_pos_nxt;
    o_h_r     <= o_h_nxt;
    o_occ_r   <= o_occ_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.status     = o_st_r;
  assign out_ch.position   = o_pos_r;
  assign out_ch.handle_out = o_h_r;
  assign out_ch.occupancy  = o_occ_r;

endmodule

/* hw/rtl/skt_checker.sv */
// ---------------------------------------------------------------------------
// skt_checker
// Port-level checks on the sorted key table, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_key_table_top_assert.svh"

module skt_checker #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  skt_req_if.sink   in_ch,
  skt_rsp_if.source out_ch
);
  import skt_pkg::*;

  logic in_acc;
  logic out_stall;
  logic miss;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_stall = out_ch.valid && !out_ch.ready;
  assign miss      = out_ch.valid && (out_ch.status == ST_NOT_FOUND);

  // one item in flight
  `SKT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ch.ready)

  `SKT_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_ch.valid && $stable(out_ch.status) && $stable(out_ch.position) && $stable(out_ch.occupancy))

  `SKT_ASSERT_IMP(a_full_occ, clk, rst_n, out_ch.valid && (out_ch.status == ST_FULL), (out_ch.occupancy == OCC_W'(DEPTH)) && (out_ch.position == '0))

  `SKT_ASSERT_IMP(a_miss_zero, clk, rst_n, miss, (out_ch.position == '0) && (out_ch.handle_out == '0))

endmodule

bind sorted_key_table_top skt_checker #(.DEPTH(DEPTH)) u_skt_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
